[design/itp_pkg.sv]
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, codes and character helpers for the integer text parser.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int DEFAULT_MAX_LEN = 255;

   localparam int VALUE_W  = 64;
   localparam int BASE_W   = 6;
   localparam int OFFSET_W = 8;
   localparam int PHASE_W  = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = BASE_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUMBER_BASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED_MODE = 1'd1;

   localparam logic [BASE_W-1:0] NUMBER_BASE_RESET = 6'd10;
   localparam logic              SIGNED_MODE_RESET = 1'b1;

   // parse phases
   localparam logic [PHASE_W-1:0] PH_WS1    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_WS2    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_START  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_HEXX   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd5;
   localparam logic [PHASE_W-1:0] PH_DONE   = 3'd6;

   localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
   localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
   localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

   // no digit: above every legal base
   localparam logic [BASE_W-1:0] NO_DIGIT = 6'd63;

   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_VT    = 8'h0B;
   localparam logic [7:0] CHR_FF    = 8'h0C;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_UA    = 8'h41;
   localparam logic [7:0] CHR_UX    = 8'h58;
   localparam logic [7:0] CHR_UZ    = 8'h5A;
   localparam logic [7:0] CHR_LA    = 8'h61;
   localparam logic [7:0] CHR_LX    = 8'h78;
   localparam logic [7:0] CHR_LZ    = 8'h7A;

   typedef struct packed {
      logic [7:0] char_in;
      logic       first_char;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value_bits;
      logic [OFFSET_W-1:0] end_offset;
      logic                done_res;
   } rsp_type;

   // parse state; nacc tracks the two's complement negation of acc
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               negative;
      logic [BASE_W-1:0]  eff_base;
      logic [VALUE_W-1:0] acc;
      logic [VALUE_W-1:0] nacc;
   } state_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_LF) ||
             (c == CHR_CR) || (c == CHR_FF) || (c == CHR_VT);
   endfunction

   function automatic logic [BASE_W-1:0] digit_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CHR_ZERO && c <= CHR_NINE) begin
         d = c - CHR_ZERO;
      end else if (c >= CHR_LA && c <= CHR_LZ) begin
         d = c - CHR_LA + 8'd10;
      end else if (c >= CHR_UA && c <= CHR_UZ) begin
         d = c - CHR_UA + 8'd10;
      end else begin
         d = {2'b00, NO_DIGIT};
      end
      return d[BASE_W-1:0];
   endfunction

endpackage

[design/itp_step.sv]
// ----------------------------------------------------------------------------
// itp_step
// Next-state and result logic for one character: sign/prefix handling and
// the multiply-add digit accumulation.
// ----------------------------------------------------------------------------
module itp_step #(
   parameter int MAX_LEN = itp_pkg::DEFAULT_MAX_LEN,
   parameter int POS_W   = $clog2(MAX_LEN + 1)
) (
   input  itp_pkg::state_type           cur_state,
   input  logic [POS_W-1:0]             cur_pos,
   input  logic [POS_W-1:0]             cur_end,
   input  itp_pkg::req_type             req,
   input  logic [itp_pkg::BASE_W-1:0]   number_base,
   input  logic                         signed_mode,
   output itp_pkg::state_type           nxt_state,
   output logic [POS_W-1:0]             nxt_pos,
   output logic [POS_W-1:0]             nxt_end,
   output itp_pkg::rsp_type             rsp
);
   import itp_pkg::*;

   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

   state_type           s;
   logic [POS_W-1:0]    pos;
   logic [POS_W-1:0]    endp;
   logic [POS_W-1:0]    nxt;
   logic [7:0]          c;
   logic [BASE_W-1:0]   d;
   logic                stop;
   logic                take;
   logic [POS_W+7:0]    end_ext;

   assign c = req.char_in;
   assign d = digit_value(c);

   always_comb begin
      s    = cur_state;
      pos  = cur_pos;
      endp = cur_end;
      if (req.first_char) begin
         s.phase    = PH_WS1;
         s.negative = 1'b0;
         s.eff_base = '0;
         s.acc      = '0;
         s.nacc     = '0;
         pos        = '0;
         endp       = '0;
      end
   end

   assign nxt = (pos < POS_MAX) ? pos + POS_W'(1) : POS_MAX;

   always_comb begin
      nxt_state = s;
      nxt_end   = endp;
      stop      = 1'b0;
      take      = 1'b0;

      // whitespace and sign stage
      if (s.phase == PH_WS1) begin
         if (is_blank(c)) begin
            stop = 1'b1;
         end else if (signed_mode && (c == CHR_MINUS || c == CHR_PLUS)) begin
            nxt_state.negative = (c == CHR_MINUS);
            nxt_state.phase    = PH_WS2;
            stop               = 1'b1;
         end else if (!signed_mode && c == CHR_PLUS) begin
            nxt_state.phase = PH_START;
            stop            = 1'b1;
         end else begin
            nxt_state.phase = PH_START;
         end
      end else if (s.phase == PH_WS2) begin
         if (is_blank(c)) begin
            stop = 1'b1;
         end else if (c == CHR_PLUS) begin
            nxt_state.phase = PH_START;
            stop            = 1'b1;
         end else begin
            nxt_state.phase = PH_START;
         end
      end

      // base selection and prefix
      if (!stop) begin
         if (nxt_state.phase == PH_START) begin
            if (number_base == BASE_ONE || number_base > BASE_MAX) begin
               nxt_state.phase = PH_DONE;
               stop            = 1'b1;
            end else if ((number_base == BASE_AUTO || number_base == BASE_HEX) &&
                         c == CHR_ZERO) begin
               nxt_state.eff_base = (number_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
               nxt_state.acc      = '0;
               nxt_state.nacc     = '0;
               nxt_end            = nxt;
               nxt_state.phase    = PH_ZERO;
               stop               = 1'b1;
            end else begin
               nxt_state.eff_base = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
               nxt_state.phase    = PH_DIGITS;
            end
         end else if (nxt_state.phase == PH_ZERO) begin
            if (c == CHR_LX || c == CHR_UX) begin
               nxt_state.eff_base = BASE_HEX;
               nxt_state.phase    = PH_HEXX;
               stop               = 1'b1;
            end else begin
               nxt_state.phase = PH_DIGITS;
            end
         end else if (nxt_state.phase == PH_HEXX) begin
            stop = 1'b1;
            if (d < BASE_HEX) begin
               take            = 1'b1;
               nxt_state.phase = PH_DIGITS;
            end else begin
               nxt_state.phase = PH_DONE;
            end
         end
      end

      if (!stop && nxt_state.phase == PH_DIGITS) begin
         if (d < nxt_state.eff_base) begin
            take = 1'b1;
         end else begin
            nxt_state.phase = PH_DONE;
         end
      end

      // multiply-add on acc and nacc; the base is the one in force after the prefix stage
      if (take) begin
         nxt_state.acc  = VALUE_W'(s.acc  * VALUE_W'(nxt_state.eff_base)) + VALUE_W'(d);
         nxt_state.nacc = VALUE_W'(s.nacc * VALUE_W'(nxt_state.eff_base)) - VALUE_W'(d);
         nxt_end        = nxt;
      end
   end

   assign nxt_pos = nxt;
   assign end_ext = {8'd0, nxt_end};

   assign rsp.value_bits = nxt_state.negative ? nxt_state.nacc : nxt_state.acc;
   assign rsp.end_offset = (end_ext > (POS_W+8)'(255)) ? 8'hFF : end_ext[7:0];
   assign rsp.done_res   = (nxt_state.phase == PH_DONE);

endmodule

[design/integer_text_parser_top.sv]
// ----------------------------------------------------------------------------
// integer_text_parser_top
// Character-serial strtol/strtoul style parser into a 64-bit value.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel carries one character per transfer; first_char restarts the
//    parse with that character as the first of a new string.
//  - rsp channel returns one result per character: value so far (negated
//    after a '-'), end offset just past the last digit, and a done flag.
//  - csr port writes number_base (index 0) and signed_mode (index 1); write
//    only while the block is idle. Reset values: base 10, signed mode on.
// Path: an accepted character sits in the input register, is evaluated and
//  lands in the result register once that register is free; rsp_valid is
//  high from then on until the transfer.
// Throughput: one character per cycle while rsp_ready stays high; the limit
//  is the parse state loop, a 64x6 multiply-add on acc and nacc per character.
// Stall: when rsp_ready is low the result holds, the input register keeps
//  one more character and req_ready drops once both are full.
// Reset: synchronous, clears both valid flags and the parse state; no
//  clearing pass is needed.
// ----------------------------------------------------------------------------
module integer_text_parser_top #(
   parameter int MAX_LEN = itp_pkg::DEFAULT_MAX_LEN
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  itp_pkg::req_type                  req_data,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output itp_pkg::rsp_type                  rsp_data,
   // register write port
   input  logic                              csr_write_en,
   input  logic [itp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [itp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import itp_pkg::*;

   localparam int POS_W = $clog2(MAX_LEN + 1);

   // configuration registers
   logic [BASE_W-1:0] number_base_ff;
   logic              signed_mode_ff;

   // input register
   logic    in_vld_ff;
   req_type in_ff;

   // result register
   logic    rsp_vld_ff;
   rsp_type rsp_ff;

   // parse state
   state_type        st_ff;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] end_ff;

   // step outputs
   state_type        st_in;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] end_in;
   rsp_type          rsp_in;

   logic advance;   // input register moves into the result register
   logic req_xfer;

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= NUMBER_BASE_RESET;
         signed_mode_ff <= SIGNED_MODE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_NUMBER_BASE: number_base_ff <= csr_wdata;
            CSR_SIGNED_MODE: signed_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   itp_step #(
      .MAX_LEN (MAX_LEN),
      .POS_W   (POS_W)
   ) u_step (
      .cur_state   (st_ff),
      .cur_pos     (pos_ff),
      .cur_end     (end_ff),
      .req         (in_ff),
      .number_base (number_base_ff),
      .signed_mode (signed_mode_ff),
      .nxt_state   (st_in),
      .nxt_pos     (pos_in),
      .nxt_end     (end_in),
      .rsp         (rsp_in)
   );

   // handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // parse state advances with each evaluated character
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.phase    <= PH_WS1;
         st_ff.negative <= 1'b0;
         st_ff.eff_base <= '0;
         st_ff.acc      <= '0;
         st_ff.nacc     <= '0;
         pos_ff         <= '0;
         end_ff         <= '0;
      end else if (advance) begin
         st_ff  <= st_in;
         pos_ff <= pos_in;
         end_ff <= end_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef NO_ASSERTIONS
   // a held result must agree with the stored phase
   a_done_matches_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ff.done_res == (st_ff.phase == PH_DONE)))
      else $error("done flag out of step with parse phase");

   // end pointer never runs past the read position
   a_end_le_pos: assert property (@(posedge clock) disable iff (reset)
      end_ff <= pos_ff)
      else $error("end position beyond read position");

   // an evaluated character always lands in the result register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("evaluated character lost");

   // empty input register never blocks the sender
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> req_ready)
      else $error("input stalled while empty");
`endif

endmodule
